@@ hdl/tlq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlq_pkg
// Shared constants for the thick line quad setup pipeline.
// ----------------------------------------------------------------------------
package tlq_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

endpackage

@@ hdl/tlq_div.sv @@
// ----------------------------------------------------------------------------
// tlq_div
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// Gives floor(num / den) when num >> QW is below den.
// ----------------------------------------------------------------------------
module tlq_div #(
  parameter int NW = 63,
  parameter int DW = 33,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int XW = ((NW - QW) > DW) ? (NW - QW) : DW;

  logic [DW-1:0] st_rem [0:QW];
  logic [DW-1:0] st_den [0:QW];
  logic [QW-1:0] st_lo  [0:QW];
  logic [QW-1:0] st_q   [0:QW];
  logic [XW-1:0] top_x;

  assign top_x     = XW'(num[NW-1:QW]);
  assign st_rem[0] = top_x[DW-1:0];
  assign st_den[0] = den;
  assign st_lo[0]  = num[QW-1:0];
  assign st_q[0]   = '0;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;

    assign r2   = {st_rem[i], st_lo[i][QW-1]};
    assign ge   = r2 >= {1'b0, st_den[i]};
    assign diff = r2 - {1'b0, st_den[i]};

    always_ff @(posedge clk) begin
      st_rem[i+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
      st_den[i+1] <= st_den[i];
      st_lo[i+1]  <= st_lo[i] << 1;
      st_q[i+1]   <= {st_q[i][QW-2:0], ge};
    end
  end

  assign quo = st_q[QW];

endmodule

@@ hdl/thick_line_quad_setup.sv @@
// ----------------------------------------------------------------------------
// thick_line_quad_setup
// Expands a segment with a thickness into the four quad corners plus the
// normalized half length and model extent.
// ----------------------------------------------------------------------------
// Fully pipelined: a request is taken every cycle (busy is always low) and its
// result appears on done, in request order, after the input, difference,
// square, radicand, root, divider operand, divider and output registers. The
// latency is set by the root stages, one root bit each, and the divider stages,
// one quotient bit each. Results are shown for one cycle.
module thick_line_quad_setup #(
  parameter int COORD_BITS = tlq_pkg::COORD_BITS,
  parameter int FRAC_BITS  = tlq_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic        [COORD_BITS-2:0] half_width,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] corner_a_x,
  output logic signed [COORD_BITS-1:0] corner_a_y,
  output logic signed [COORD_BITS-1:0] corner_b_x,
  output logic signed [COORD_BITS-1:0] corner_b_y,
  output logic signed [COORD_BITS-1:0] corner_c_x,
  output logic signed [COORD_BITS-1:0] corner_c_y,
  output logic signed [COORD_BITS-1:0] corner_d_x,
  output logic signed [COORD_BITS-1:0] corner_d_y,
  output logic        [COORD_BITS-2:0] norm_length,
  output logic        [COORD_BITS-2:0] model_extent,
  output logic                         zero_thickness
);

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int TW   = CB - 1;          // thickness / quotient width
  localparam int RW   = CB + 1;          // root width
  localparam int SQW  = 2 * RW;          // radicand width
  localparam int REMW = RW + 3;
  localparam int PW   = TW + CB;         // t * |d|
  localparam int NNW  = RW + FB;         // len << FB
  localparam int SBW  = 4 * CB + TW + 2 * CB + 2;   // pre-root sideband
  localparam int EBW  = 4 * CB + TW + 4;            // post-root sideband
  localparam logic [TW-1:0] UMAX = {TW{1'b1}};
  localparam logic [TW-1:0] ONE  = TW'(1) << FB;

  function automatic logic [CB-1:0] sat(input logic signed [CB+1:0] v);
    logic signed [CB+1:0] hi;
    logic signed [CB+1:0] lo;
    hi = $signed({3'b000, {(CB-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return hi[CB-1:0];
    else if (v < lo) return lo[CB-1:0];
    else return v[CB-1:0];
  endfunction

  assign busy = 1'b0;

  // stage A: input capture
  logic              a_vld;
  logic [CB-1:0]     a_sx, a_sy, a_ex, a_ey;
  logic [TW-1:0]     a_t;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= start;
    a_sx <= start_x;
    a_sy <= start_y;
    a_ex <= end_x;
    a_ey <= end_y;
    a_t  <= half_width;
  end

  // stage B: differences
  logic [CB:0]   dx, dy;
  logic [CB:0]   ndx_w, ndy_w;
  logic          b_vld;
  logic [CB-1:0] b_sx, b_sy, b_ex, b_ey, b_adx, b_ady;
  logic [TW-1:0] b_t;
  logic          b_ndx, b_ndy;

  assign dx    = {a_ex[CB-1], a_ex} - {a_sx[CB-1], a_sx};
  assign dy    = {a_ey[CB-1], a_ey} - {a_sy[CB-1], a_sy};
  assign ndx_w = -dx;
  assign ndy_w = -dy;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else     b_vld <= a_vld;
    b_sx  <= a_sx;
    b_sy  <= a_sy;
    b_ex  <= a_ex;
    b_ey  <= a_ey;
    b_t   <= a_t;
    b_ndx <= dx[CB];
    b_ndy <= dy[CB];
    b_adx <= dx[CB] ? ndx_w[CB-1:0] : dx[CB-1:0];
    b_ady <= dy[CB] ? ndy_w[CB-1:0] : dy[CB-1:0];
  end

  // stage C: squares
  logic            c_vld;
  logic [2*CB-1:0] c_sqx, c_sqy;
  logic [SBW-1:0]  c_sb;

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else     c_vld <= b_vld;
    c_sqx <= b_adx * b_adx;
    c_sqy <= b_ady * b_ady;
    c_sb  <= {b_sx, b_sy, b_ex, b_ey, b_t, b_adx, b_ady, b_ndx, b_ndy};
  end

  // stage D: radicand, then root stages
  logic             sq_vld [0:RW];
  logic [SQW-1:0]   sq_rad [0:RW];
  logic [REMW-1:0]  sq_rem [0:RW];
  logic [RW-1:0]    sq_root[0:RW];
  logic [SBW-1:0]   sq_sb  [0:RW];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else     sq_vld[0] <= c_vld;
    sq_rad[0]  <= SQW'(c_sqx) + SQW'(c_sqy);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_sb[0]   <= c_sb;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW-1:0] r4;
    logic [REMW-1:0] trial;
    logic            ge;

    assign r4    = {sq_rem[k][REMW-3:0], sq_rad[k][SQW-1 -: 2]};
    assign trial = REMW'({sq_root[k], 2'b01});
    assign ge    = r4 >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else     sq_vld[k+1] <= sq_vld[k];
      sq_rad[k+1]  <= sq_rad[k] << 2;
      sq_rem[k+1]  <= ge ? r4 - trial : r4;
      sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
      sq_sb[k+1]   <= sq_sb[k];
    end
  end

  // stage E: divider operands
  logic [CB-1:0]  s_sx, s_sy, s_ex, s_ey, s_adx, s_ady;
  logic [TW-1:0]  s_t;
  logic           s_ndx, s_ndy;
  logic [RW-1:0]  len;
  logic [NNW-1:0] nnum;
  logic [CB-1:0]  nden;

  assign {s_sx, s_sy, s_ex, s_ey, s_t, s_adx, s_ady, s_ndx, s_ndy} = sq_sb[RW];
  assign len  = sq_root[RW];
  assign nnum = {len, {FB{1'b0}}};
  assign nden = {s_t, 1'b0};

  logic           e_vld;
  logic [PW-1:0]  e_px, e_py;
  logic [RW-1:0]  e_len;
  logic [NNW-1:0] e_nnum;
  logic [CB-1:0]  e_nden;
  logic [EBW-1:0] e_sb;

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else     e_vld <= sq_vld[RW];
    e_px   <= s_t * s_ady;
    e_py   <= s_t * s_adx;
    e_len  <= (len == '0) ? RW'(1) : len;
    e_nnum <= nnum;
    e_nden <= (s_t == '0) ? CB'(1) : nden;
    // saturate when the quotient would not fit in TW bits
    e_sb   <= {s_sx, s_sy, s_ex, s_ey, s_t, s_ndx, s_ndy, len == '0,
               (nnum >> TW) >= NNW'(nden)};
  end

  logic [TW-1:0] mx, my, nq;

  tlq_div #(.NW(PW), .DW(RW), .QW(TW)) u_div_x (
    .clk (clk), .num (e_px), .den (e_len), .quo (mx));

  tlq_div #(.NW(PW), .DW(RW), .QW(TW)) u_div_y (
    .clk (clk), .num (e_py), .den (e_len), .quo (my));

  tlq_div #(.NW(NNW), .DW(CB), .QW(TW)) u_div_n (
    .clk (clk), .num (e_nnum), .den (e_nden), .quo (nq));

  logic           dv_vld [0:TW];
  logic [EBW-1:0] dv_sb  [0:TW];

  assign dv_vld[0] = e_vld;
  assign dv_sb[0]  = e_sb;

  for (genvar j = 0; j < TW; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) dv_vld[j+1] <= 1'b0;
      else     dv_vld[j+1] <= dv_vld[j];
      dv_sb[j+1] <= dv_sb[j];
    end
  end

  // stage F: corners and outputs
  logic [CB-1:0]        f_sx, f_sy, f_ex, f_ey;
  logic [TW-1:0]        f_t;
  logic                 f_ndx, f_ndy, f_lz, f_ovf;
  logic signed [CB+1:0] tx, ty, wsx, wsy, wex, wey;
  logic [TW-1:0]        norm;
  logic [CB-1:0]        ext;

  assign {f_sx, f_sy, f_ex, f_ey, f_t, f_ndx, f_ndy, f_lz, f_ovf} = dv_sb[TW];

  always_comb begin
    if (f_lz) begin
      tx = $signed({3'b000, f_t});
      ty = '0;
    end else begin
      tx = f_ndy ? -$signed({3'b000, mx}) : $signed({3'b000, mx});
      ty = f_ndx ? -$signed({3'b000, my}) : $signed({3'b000, my});
    end
    wsx = $signed({{2{f_sx[CB-1]}}, f_sx});
    wsy = $signed({{2{f_sy[CB-1]}}, f_sy});
    wex = $signed({{2{f_ex[CB-1]}}, f_ex});
    wey = $signed({{2{f_ey[CB-1]}}, f_ey});
    if (f_t == '0)  norm = '0;
    else if (f_ovf) norm = UMAX;
    else            norm = nq;
    ext = {1'b0, norm} + {1'b0, ONE};
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_vld[TW];
    corner_a_x     <= sat(wex + ty - tx);
    corner_a_y     <= sat(wey + ty + tx);
    corner_b_x     <= sat(wsx - ty - tx);
    corner_b_y     <= sat(wsy + ty - tx);
    corner_c_x     <= sat(wsx - ty + tx);
    corner_c_y     <= sat(wsy - ty - tx);
    corner_d_x     <= sat(wex + ty + tx);
    corner_d_y     <= sat(wey - ty + tx);
    norm_length    <= norm;
    model_extent   <= ext[CB-1] ? UMAX : ext[TW-1:0];
    zero_thickness <= (f_t == '0);
  end

`ifndef NO_ASSERTIONS
  a_zero_t: assert property (@(posedge clk) disable iff (rst)
    done && zero_thickness |-> norm_length == '0 && model_extent == ONE)
    else $error("zero thickness result has nonzero length");

  a_ext_ge: assert property (@(posedge clk) disable iff (rst)
    done |-> model_extent >= norm_length)
    else $error("model extent below normalized length");

  a_root_idle: assert property (@(posedge clk) disable iff (rst)
    !sq_vld[0] && !c_vld |=> !sq_vld[1])
    else $error("root stage valid without upstream request");
`endif

endmodule
